### rtl/table_scalar_quantizer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the table scalar quantizer.
// Assertions are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TABLE_SCALAR_QUANTIZER_DEFINES_SVH
`define TABLE_SCALAR_QUANTIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define TSQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TSQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TSQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TSQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// Table scalar quantizer package
// Field widths, opcodes and the control bundle passed between search stages.
// ----------------------------------------------------------------------------
`default_nettype none

package tsq_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int ADDR_FIELD_W  = 8;
	localparam int VALUE_FIELD_W = 16;
	localparam int INDEX_W       = 8;
	localparam int LEVEL_OUT_W   = 16;
	localparam int IN_TDATA_W    = SAMPLE_W + ADDR_FIELD_W + VALUE_FIELD_W;
	localparam int OUT_TDATA_W   = INDEX_W + LEVEL_OUT_W;
	localparam int CFG_W         = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUANT = 1'b1
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} stage_ctl_t;

endpackage

`default_nettype wire

### rtl/tsq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_a_q;
	logic [WIDTH-1:0] rd_data_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a_q <= mem_q[rd_addr_a];
			rd_data_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

`default_nettype wire

### rtl/tsq_stage.sv
// ----------------------------------------------------------------------------
// Search stage
// One binary search step with its own copy of the level table.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_stage #(
	parameter int MAX_BITS    = 8,
	parameter int LEVEL_WIDTH = 16,
	parameter int STAGE       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          active,
	input  tsq_pkg::stage_ctl_t           up_ctl,
	output logic                          up_ready,
	input  logic [tsq_pkg::SAMPLE_W-1:0]  up_sample,
	input  logic [MAX_BITS-1:0]           up_pos,
	input  logic [MAX_BITS-1:0]           up_waddr,
	input  logic [LEVEL_WIDTH-1:0]        up_wdata,
	output tsq_pkg::stage_ctl_t           dn_ctl,
	input  logic                          dn_ready,
	output logic [tsq_pkg::SAMPLE_W-1:0]  dn_sample,
	output logic [MAX_BITS-1:0]           dn_pos,
	output logic [MAX_BITS-1:0]           dn_waddr,
	output logic [LEVEL_WIDTH-1:0]        dn_wdata,
	output logic [LEVEL_WIDTH-1:0]        dn_level
);

	import tsq_pkg::*;

	localparam bit LAST    = (STAGE == MAX_BITS - 1);
	localparam int STEP_SH = LAST ? 0 : MAX_BITS - 2 - STAGE;
	localparam logic [MAX_BITS-1:0] STEP = MAX_BITS'(1) << STEP_SH;
	localparam int CMP_W   = ((LEVEL_WIDTH > SAMPLE_W) ? LEVEL_WIDTH : SAMPLE_W) + 1;
	localparam int DEPTH   = 1 << MAX_BITS;

	stage_ctl_t                 ctl_s1;
	logic [SAMPLE_W-1:0]        sample_s1;
	logic [MAX_BITS-1:0]        pos_s1;
	logic [MAX_BITS-1:0]        waddr_s1;
	logic [LEVEL_WIDTH-1:0]     wdata_s1;

	logic                       load;
	logic                       wr_en;
	logic                       rd_en;
	logic [LEVEL_WIDTH-1:0]     lo;
	logic [LEVEL_WIDTH-1:0]     hi;
	logic signed [CMP_W-1:0]    lo_ext;
	logic signed [CMP_W-1:0]    hi_ext;
	logic signed [CMP_W-1:0]    sum;
	logic signed [CMP_W-1:0]    x2;
	logic                       above;

	assign up_ready = !ctl_s1.valid || dn_ready;
	assign load     = up_ready && up_ctl.valid;
	assign wr_en    = load && (up_ctl.op == OP_WRITE);
	assign rd_en    = load && (up_ctl.op == OP_QUANT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (up_ready) begin
			ctl_s1 <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s1 <= up_sample;
			pos_s1    <= up_pos;
			waddr_s1  <= up_waddr;
			wdata_s1  <= up_wdata;
		end
	end

	// A write word updates this copy as it enters, so later words see it here.
	tsq_ram #(
		.WIDTH (LEVEL_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (up_waddr),
		.wr_data   (up_wdata),
		.rd_en     (rd_en),
		.rd_addr_a (up_pos - MAX_BITS'(1)),
		.rd_addr_b (up_pos),
		.rd_data_a (lo),
		.rd_data_b (hi)
	);

	always_comb begin
		lo_ext = CMP_W'(signed'(lo));
		hi_ext = CMP_W'(signed'(hi));
		sum    = lo_ext + hi_ext;
		x2     = CMP_W'(signed'(sample_s1)) <<< 1;
		above  = x2 > sum;
	end

	always_comb begin
		if (!active) begin
			dn_pos = pos_s1;
		end else if (above) begin
			dn_pos = LAST ? pos_s1 : pos_s1 + STEP;
		end else begin
			dn_pos = pos_s1 - STEP;
		end
	end

	assign dn_level  = above ? hi : lo;
	assign dn_ctl    = ctl_s1;
	assign dn_sample = sample_s1;
	assign dn_waddr  = waddr_s1;
	assign dn_wdata  = wdata_s1;

endmodule

`default_nettype wire

### rtl/table_scalar_quantizer.sv
// ----------------------------------------------------------------------------
// Table scalar quantizer
// Nonuniform quantizer by pipelined binary search over a table of levels.
// ----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready. s_tuser selects the operation: a
// write word stores entry_value at entry_addr, a quantize word searches the
// first 2^bits_in_use levels for the one nearest to sample and returns its
// index and value on m_tvalid/m_tready. Write words return nothing.
// bits_in_use is loaded through cfg_valid/cfg_ready, which is always ready;
// it must only change while no word is in flight.
// The pipeline takes one word per cycle unless the receiver stalls: each of
// the MAX_BITS stages performs one search step and holds its own copy of the
// table with two read ports. A write word updates each copy as it passes, so
// words stay in order with respect to the table.
// Reset clears all valid bits and sets bits_in_use to 8. Table contents are
// undefined until written.
// When the receiver stalls, the output register holds its word, the stages
// keep filling empty slots, and s_tready drops once the pipeline is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "table_scalar_quantizer_defines.svh"

module table_scalar_quantizer #(
	parameter int MAX_BITS    = 8,
	parameter int LEVEL_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tsq_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// sample [15:0], entry_addr [23:16], entry_value [39:24]
	input  logic [tsq_pkg::IN_TDATA_W-1:0]  s_tdata,
	// opcode [0]
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// level_index [7:0], level_value [23:8]
	output logic [tsq_pkg::OUT_TDATA_W-1:0] m_tdata
);

	import tsq_pkg::*;

	logic [CFG_W-1:0]        bits_q;
	logic [CFG_W-1:0]        eff_bits;
	logic [MAX_BITS-1:0]     act;

	stage_ctl_t              ctl_w    [MAX_BITS];
	logic                    rdy_w    [MAX_BITS];
	logic [SAMPLE_W-1:0]     sample_w [MAX_BITS];
	logic [MAX_BITS-1:0]     pos_w    [MAX_BITS];
	logic [MAX_BITS-1:0]     waddr_w  [MAX_BITS];
	logic [LEVEL_WIDTH-1:0]  wdata_w  [MAX_BITS];

	stage_ctl_t              last_ctl;
	logic                    last_ready;
	logic [MAX_BITS-1:0]     last_idx;
	logic [LEVEL_WIDTH-1:0]  last_level;
	logic                    last_quant;
	logic                    last_write;

	logic                    out_valid_q;
	logic [INDEX_W-1:0]      out_index_q;
	logic [LEVEL_OUT_W-1:0]  out_value_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= CFG_RESET;
		end else if (cfg_valid) begin
			bits_q <= cfg_data;
		end
	end

	always_comb begin
		if (bits_q == '0) begin
			eff_bits = CFG_W'(1);
		end else if (bits_q > CFG_W'(MAX_BITS)) begin
			eff_bits = CFG_W'(MAX_BITS);
		end else begin
			eff_bits = bits_q;
		end
	end

	// Stages ahead of the first step for the chosen resolution pass through.
	always_comb begin
		for (int j = 0; j < MAX_BITS; j++) begin
			act[j] = eff_bits > CFG_W'(MAX_BITS - 1 - j);
		end
	end

	assign ctl_w[0].valid = s_tvalid;
	assign ctl_w[0].op    = op_t'(s_tuser[0]);
	assign sample_w[0]    = s_tdata[SAMPLE_W-1:0];
	assign pos_w[0]       = MAX_BITS'(1) << (eff_bits - CFG_W'(1));
	assign waddr_w[0]     = MAX_BITS'(s_tdata[SAMPLE_W +: ADDR_FIELD_W]);
	assign wdata_w[0]     =
		LEVEL_WIDTH'(signed'(s_tdata[SAMPLE_W + ADDR_FIELD_W +: VALUE_FIELD_W]));

	assign s_tready = rdy_w[0];

	for (genvar j = 0; j < MAX_BITS; j++) begin : g_stage
		if (j == MAX_BITS - 1) begin : g_last
			tsq_stage #(
				.MAX_BITS    (MAX_BITS),
				.LEVEL_WIDTH (LEVEL_WIDTH),
				.STAGE       (j)
			) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.active    (act[j]),
				.up_ctl    (ctl_w[j]),
				.up_ready  (rdy_w[j]),
				.up_sample (sample_w[j]),
				.up_pos    (pos_w[j]),
				.up_waddr  (waddr_w[j]),
				.up_wdata  (wdata_w[j]),
				.dn_ctl    (last_ctl),
				.dn_ready  (last_ready),
				.dn_sample (),
				.dn_pos    (last_idx),
				.dn_waddr  (),
				.dn_wdata  (),
				.dn_level  (last_level)
			);
		end else begin : g_mid
			tsq_stage #(
				.MAX_BITS    (MAX_BITS),
				.LEVEL_WIDTH (LEVEL_WIDTH),
				.STAGE       (j)
			) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.active    (act[j]),
				.up_ctl    (ctl_w[j]),
				.up_ready  (rdy_w[j]),
				.up_sample (sample_w[j]),
				.up_pos    (pos_w[j]),
				.up_waddr  (waddr_w[j]),
				.up_wdata  (wdata_w[j]),
				.dn_ctl    (ctl_w[j+1]),
				.dn_ready  (rdy_w[j+1]),
				.dn_sample (sample_w[j+1]),
				.dn_pos    (pos_w[j+1]),
				.dn_waddr  (waddr_w[j+1]),
				.dn_wdata  (wdata_w[j+1]),
				.dn_level  ()
			);
		end
	end

	assign last_ready = !out_valid_q || m_tready;
	assign last_quant = last_ctl.valid && (last_ctl.op == OP_QUANT);
	assign last_write = last_ctl.valid && (last_ctl.op == OP_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_ready) begin
			out_valid_q <= last_quant;
		end
	end

	always_ff @(posedge clk) begin
		if (last_ready && last_quant) begin
			out_index_q <= INDEX_W'(last_idx);
			out_value_q <= LEVEL_OUT_W'(signed'(last_level));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_value_q, out_index_q};

	`TSQ_ASSERT_IMP(a_empty_out_takes_word, clk, arst_n, !out_valid_q, s_tready)
	`TSQ_ASSERT_NXT(a_quant_gives_word, clk, arst_n, last_quant && last_ready, out_valid_q)
	`TSQ_ASSERT_NXT(a_write_gives_none, clk, arst_n, last_write && last_ready, !out_valid_q)

endmodule

`default_nettype wire
